>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define WSJS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form built on the macro above.
`define WSJS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    `WSJS_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

>>> hdl/wsjs_pkg.sv
// ----------------------------------------------------------------------------
// wsjs_pkg
// Shared sizes, codes, pointer helpers and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package wsjs_pkg;

    localparam int unsigned MAX_WORKERS    = 8;
    localparam int unsigned DEQUE_DEPTH    = 64;
    localparam int unsigned OVERFLOW_DEPTH = 64;
    localparam int unsigned HANDLE_BITS    = 16;

    localparam int unsigned REQ_W   = 2;
    localparam int unsigned JOB_W   = 16;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned CFG_W   = 4;
    localparam int unsigned OUTS_W  = 16;
    localparam int unsigned STEAL_W = 32;
    localparam int unsigned WPORT_W = 3;

    localparam int unsigned WIDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int unsigned NCNT_W = $clog2(MAX_WORKERS + 1);
    localparam int unsigned DQ_AW  = $clog2(DEQUE_DEPTH);
    localparam int unsigned DQ_PW  = $clog2(2 * DEQUE_DEPTH);
    localparam int unsigned OV_AW  = $clog2(OVERFLOW_DEPTH);
    localparam int unsigned OV_PW  = $clog2(2 * OVERFLOW_DEPTH);
    localparam int unsigned DQ_MAW = WIDX_W + DQ_AW;

    localparam logic [31:0] SEED_STEP = 32'h9e37_79b9;
    localparam logic [JOB_W-1:0] HANDLE_MASK = (HANDLE_BITS >= JOB_W) ? {JOB_W{1'b1}} :
        JOB_W'((64'd1 << HANDLE_BITS) - 64'd1);

    localparam logic [DQ_PW-1:0] DQ_WRAP_M1 = DQ_PW'(2 * DEQUE_DEPTH - 1);
    localparam logic [DQ_PW-1:0] DQ_DEP     = DQ_PW'(DEQUE_DEPTH);
    localparam logic [DQ_PW:0]   DQ_WRAP    = (DQ_PW + 1)'(2 * DEQUE_DEPTH);
    localparam logic [OV_PW-1:0] OV_WRAP_M1 = OV_PW'(2 * OVERFLOW_DEPTH - 1);
    localparam logic [OV_PW-1:0] OV_DEP     = OV_PW'(OVERFLOW_DEPTH);
    localparam logic [OV_PW:0]   OV_WRAP    = (OV_PW + 1)'(2 * OVERFLOW_DEPTH);

    typedef enum logic [REQ_W-1:0] {
        RQ_SUBMIT   = 2'd0,
        RQ_ACQUIRE  = 2'd1,
        RQ_COMPLETE = 2'd2,
        RQ_NONE     = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_PUSH_OWN  = 3'd0,
        ST_QUEUED_OV = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_GOT_OWN   = 3'd3,
        ST_GOT_OV    = 3'd4,
        ST_STOLEN    = 3'd5,
        ST_NONE      = 3'd6,
        ST_COMPLETED = 3'd7
    } t_status;

    typedef struct packed {
        logic    latch;
        logic    dq_push;
        logic    ov_push;
        logic    dq_pop;
        logic    ov_pop;
        logic    steal;
        logic    scan_start;
        logic    scan_step;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_status;
        t_status status;
        logic    load_job;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic has_own;
        logic own_full;
        logic own_empty;
        logic ov_full;
        logic ov_empty;
        logic multi;
        logic scan_done;
        logic scan_skip;
        logic out_free;
    } t_dp_stat;

    function automatic logic [DQ_PW-1:0] dq_inc(input logic [DQ_PW-1:0] p);
        return (p == DQ_WRAP_M1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [DQ_PW-1:0] dq_dec(input logic [DQ_PW-1:0] p);
        return (p == '0) ? DQ_WRAP_M1 : p - 1'b1;
    endfunction

    function automatic logic [DQ_PW-1:0] dq_used(input logic [DQ_PW-1:0] b,
                                                  input logic [DQ_PW-1:0] t);
        logic [DQ_PW:0] s;
        s = (b >= t) ? ({1'b0, b} - {1'b0, t}) : ({1'b0, b} + DQ_WRAP - {1'b0, t});
        return s[DQ_PW-1:0];
    endfunction

    function automatic logic [DQ_AW-1:0] dq_slot(input logic [DQ_PW-1:0] p);
        logic [DQ_PW-1:0] s;
        s = (p >= DQ_DEP) ? p - DQ_DEP : p;
        return s[DQ_AW-1:0];
    endfunction

    function automatic logic [OV_PW-1:0] ov_inc(input logic [OV_PW-1:0] p);
        return (p == OV_WRAP_M1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [OV_PW-1:0] ov_used(input logic [OV_PW-1:0] tl,
                                                  input logic [OV_PW-1:0] hd);
        logic [OV_PW:0] s;
        s = (tl >= hd) ? ({1'b0, tl} - {1'b0, hd}) : ({1'b0, tl} + OV_WRAP - {1'b0, hd});
        return s[OV_PW-1:0];
    endfunction

    function automatic logic [OV_AW-1:0] ov_slot(input logic [OV_PW-1:0] p);
        logic [OV_PW-1:0] s;
        s = (p >= OV_DEP) ? p - OV_DEP : p;
        return s[OV_AW-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/work_stealing_job_scheduler.sv
// ----------------------------------------------------------------------------
// work_stealing_job_scheduler
// Per-worker job deques with a shared overflow FIFO and randomized stealing.
// ----------------------------------------------------------------------------
// The request channel (i_in_valid / o_in_stall) carries one word per request:
// submit, acquire or complete, with the requester and a job handle. The result
// channel (o_out_valid / i_out_stall) returns exactly one word per request with
// the status, the handed-out job, the victim and the two counters.
// One request is worked on at a time. A submit, complete or unknown request
// passes from acceptance through the decide state to the result register; an
// acquire served from the own deque or the overflow FIFO also passes the read
// wait state, since both stores are memories with a registered read port. An
// acquire that reaches the steal phase walks the victims one per cycle through
// the pointer registers, up to active_workers of them, and a stolen job is
// then read through the same wait state.
// The next request can be accepted in the cycle after the hand-off.
// The request side is stalled from acceptance until the result word has been
// loaded into the output register. While the receiver stalls, a finished word
// waits in that register and the next request may already be accepted and
// worked up to its own hand-off.
// Synchronous reset empties all deques and the FIFO, clears both counters and
// the victim seed, sets the worker count to one and drops o_out_valid. The
// store contents are not cleared; only entries between pointers are read.
// The active_workers register is written through i_cfg_we / i_cfg_data and is
// clamped into one to eight workers when written.
// ----------------------------------------------------------------------------
`default_nettype none

module work_stealing_job_scheduler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [wsjs_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [wsjs_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic                          i_from_external,
    input  wire logic [wsjs_pkg::WPORT_W-1:0]  i_worker_index,
    input  wire logic [wsjs_pkg::JOB_W-1:0]    i_job_handle,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [wsjs_pkg::STAT_W-1:0]        o_status,
    output logic [wsjs_pkg::JOB_W-1:0]         o_job_out,
    output logic [wsjs_pkg::WPORT_W-1:0]       o_victim_index,
    output logic [wsjs_pkg::OUTS_W-1:0]        o_outstanding_jobs,
    output logic [wsjs_pkg::STEAL_W-1:0]       o_steal_total
);

    wsjs_pkg::t_cmd     cmd;
    wsjs_pkg::t_dp_stat dp_stat;

    // The sequencer owns all decisions; the datapath only executes commands.
    wsjs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (cmd)
    );

    wsjs_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_req_type         (i_req_type),
        .i_from_external    (i_from_external),
        .i_worker_index     (i_worker_index),
        .i_job_handle       (i_job_handle),
        .i_out_stall        (i_out_stall),
        .i_cmd              (cmd),
        .o_stat             (dp_stat),
        .o_out_valid        (o_out_valid),
        .o_status           (o_status),
        .o_job_out          (o_job_out),
        .o_victim_index     (o_victim_index),
        .o_outstanding_jobs (o_outstanding_jobs),
        .o_steal_total      (o_steal_total)
    );

endmodule

`default_nettype wire

>>> hdl/wsjs_datapath.sv
// ----------------------------------------------------------------------------
// wsjs_datapath
// Deque and overflow stores, pointers, victim residues, counters, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module wsjs_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [wsjs_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic [wsjs_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic                           i_from_external,
    input  wire logic [wsjs_pkg::WPORT_W-1:0]   i_worker_index,
    input  wire logic [wsjs_pkg::JOB_W-1:0]     i_job_handle,
    input  wire logic                           i_out_stall,
    input  wire wsjs_pkg::t_cmd                 i_cmd,
    output wsjs_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_valid,
    output logic [wsjs_pkg::STAT_W-1:0]         o_status,
    output logic [wsjs_pkg::JOB_W-1:0]          o_job_out,
    output logic [wsjs_pkg::WPORT_W-1:0]        o_victim_index,
    output logic [wsjs_pkg::OUTS_W-1:0]         o_outstanding_jobs,
    output logic [wsjs_pkg::STEAL_W-1:0]        o_steal_total
);

    localparam int unsigned W  = wsjs_pkg::WIDX_W;
    localparam int unsigned NW = wsjs_pkg::NCNT_W;
    localparam int unsigned MW = wsjs_pkg::MAX_WORKERS;

    logic [NW-1:0]                   r_n;
    logic [wsjs_pkg::REQ_W-1:0]      r_req;
    logic                            r_ext;
    logic [wsjs_pkg::WPORT_W-1:0]    r_widx;
    logic [wsjs_pkg::JOB_W-1:0]      r_handle;

    logic [wsjs_pkg::DQ_PW-1:0]      r_top [MW];
    logic [wsjs_pkg::DQ_PW-1:0]      r_bot [MW];
    logic [wsjs_pkg::OV_PW-1:0]      r_head;
    logic [wsjs_pkg::OV_PW-1:0]      r_tail;
    logic [31:0]                     r_seed;
    logic [W-1:0]                    r_res [1:MW];
    logic [W-1:0]                    r_v;
    logic [NW-1:0]                   r_k;
    logic [wsjs_pkg::OUTS_W-1:0]     r_outs;
    logic [wsjs_pkg::STEAL_W-1:0]    r_steal;
    logic                            r_from_ov;

    logic [wsjs_pkg::JOB_W-1:0]      r_dq_mem [2**wsjs_pkg::DQ_MAW];
    logic [wsjs_pkg::JOB_W-1:0]      r_ov_mem [2**wsjs_pkg::OV_AW];
    logic [wsjs_pkg::JOB_W-1:0]      r_dq_rd;
    logic [wsjs_pkg::JOB_W-1:0]      r_ov_rd;

    logic [wsjs_pkg::STAT_W-1:0]     r_status;
    logic [wsjs_pkg::JOB_W-1:0]      r_job;
    logic [W-1:0]                    r_victim;
    logic                            r_out_valid;
    logic [wsjs_pkg::STAT_W-1:0]     r_o_status;
    logic [wsjs_pkg::JOB_W-1:0]      r_o_job;
    logic [W-1:0]                    r_o_victim;
    logic [wsjs_pkg::OUTS_W-1:0]     r_o_outs;
    logic [wsjs_pkg::STEAL_W-1:0]    r_o_steal;

    logic [NW-1:0]                   n_cfg;
    logic [W-1:0]                    own;
    logic                            has_own;
    logic [wsjs_pkg::DQ_PW-1:0]      own_used;
    logic [wsjs_pkg::DQ_PW-1:0]      vic_used;
    logic [wsjs_pkg::OV_PW-1:0]      ov_cnt;
    logic [NW-1:0]                   v_next;
    logic [wsjs_pkg::DQ_MAW-1:0]     dq_wa;
    logic [wsjs_pkg::DQ_MAW-1:0]     dq_ra;
    logic                            out_free;
    logic [32:0]                     seed_sum;

    // The worker count is clamped when written.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cfg = NW'(1);
        end else if ({1'b0, i_cfg_data} > (wsjs_pkg::CFG_W + 1)'(MW)) begin
            n_cfg = NW'(MW);
        end else begin
            n_cfg = NW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= NW'(1);
        end else if (i_cfg_we) begin
            r_n <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req    <= i_req_type;
            r_ext    <= i_from_external;
            r_widx   <= i_worker_index;
            r_handle <= i_job_handle & wsjs_pkg::HANDLE_MASK;
        end
    end

    assign own      = W'(r_widx);
    assign has_own  = !r_ext && ({{(NW > wsjs_pkg::WPORT_W ? NW - wsjs_pkg::WPORT_W : 0){1'b0}},
                      r_widx} < (wsjs_pkg::WPORT_W + NW)'(r_n));
    assign own_used = wsjs_pkg::dq_used(r_bot[own], r_top[own]);
    assign vic_used = wsjs_pkg::dq_used(r_bot[r_v], r_top[r_v]);
    assign ov_cnt   = wsjs_pkg::ov_used(r_tail, r_head);
    assign v_next   = ((NW'(r_v) + 1'b1) == r_n) ? '0 : NW'(r_v) + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.req       = wsjs_pkg::t_req'(r_req);
        o_stat.has_own   = has_own;
        o_stat.own_full  = (own_used == wsjs_pkg::DQ_DEP);
        o_stat.own_empty = (own_used == '0);
        o_stat.ov_full   = (ov_cnt == wsjs_pkg::OV_DEP);
        o_stat.ov_empty  = (ov_cnt == '0);
        o_stat.multi     = (r_n > NW'(1));
        o_stat.scan_done = (r_k == r_n);
        o_stat.scan_skip = (has_own && (r_v == own)) || (vic_used == '0);
        o_stat.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MW; i++) begin
                r_top[i] <= '0;
                r_bot[i] <= '0;
            end
        end else if (i_cmd.dq_push) begin
            r_bot[own] <= wsjs_pkg::dq_inc(r_bot[own]);
        end else if (i_cmd.dq_pop) begin
            r_bot[own] <= wsjs_pkg::dq_dec(r_bot[own]);
        end else if (i_cmd.steal) begin
            r_top[r_v] <= wsjs_pkg::dq_inc(r_top[r_v]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (i_cmd.ov_push) begin
                r_tail <= wsjs_pkg::ov_inc(r_tail);
            end
            if (i_cmd.ov_pop) begin
                r_head <= wsjs_pkg::ov_inc(r_head);
            end
        end
    end

    // The 32-bit victim seed. Its carry out tells the residues below when the
    // seed wrapped, which takes 2^32 off its value.
    assign seed_sum = {1'b0, r_seed} + {1'b0, wsjs_pkg::SEED_STEP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cmd.scan_start) begin
            r_seed <= seed_sum[31:0];
        end
    end

    // Residue of the victim seed modulo each possible worker count. On a wrap
    // the residue also gains the negated residue of 2^32.
    for (genvar g = 1; g <= MW; g++) begin : g_res
        localparam int unsigned SM = wsjs_pkg::SEED_STEP % g;
        localparam int unsigned WR = int'((64'd1 << 32) % g);
        localparam int unsigned WF = (WR == 0) ? 0 : g - WR;
        logic [W+1:0] sum;
        assign sum = {2'b00, r_res[g]} + (W + 2)'(SM) +
                     (seed_sum[32] ? (W + 2)'(WF) : (W + 2)'(0));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_res[g] <= '0;
            end else if (i_cmd.scan_start) begin
                if (sum >= (W + 2)'(2 * g)) begin
                    r_res[g] <= W'(sum - (W + 2)'(2 * g));
                end else if (sum >= (W + 2)'(g)) begin
                    r_res[g] <= W'(sum - (W + 2)'(g));
                end else begin
                    r_res[g] <= sum[W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_v <= r_res[r_n];
            r_k <= '0;
        end else if (i_cmd.scan_step) begin
            r_v <= W'(v_next);
            r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outs  <= '0;
            r_steal <= '0;
        end else begin
            if (i_cmd.cnt_inc && (r_outs != '1)) begin
                r_outs <= r_outs + 1'b1;
            end else if (i_cmd.cnt_dec && (r_outs != '0)) begin
                r_outs <= r_outs - 1'b1;
            end
            if (i_cmd.steal) begin
                r_steal <= r_steal + 1'b1;
            end
        end
    end

    assign dq_wa = {own, wsjs_pkg::dq_slot(r_bot[own])};
    assign dq_ra = i_cmd.steal ? {r_v, wsjs_pkg::dq_slot(r_top[r_v])}
                               : {own, wsjs_pkg::dq_slot(wsjs_pkg::dq_dec(r_bot[own]))};

    always_ff @(posedge i_clk) begin
        if (i_cmd.dq_push) begin
            r_dq_mem[dq_wa] <= r_handle;
        end
        r_dq_rd <= r_dq_mem[dq_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ov_push) begin
            r_ov_mem[wsjs_pkg::ov_slot(r_tail)] <= r_handle;
        end
        r_ov_rd <= r_ov_mem[wsjs_pkg::ov_slot(r_head)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_job    <= '0;
            r_victim <= '0;
        end else begin
            if (i_cmd.load_job) begin
                r_job <= r_from_ov ? r_ov_rd : r_dq_rd;
            end
            if (i_cmd.steal) begin
                r_victim <= r_v;
            end
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.dq_pop || i_cmd.steal || i_cmd.ov_pop) begin
            r_from_ov <= i_cmd.ov_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_job    <= r_job;
            r_o_victim <= r_victim;
            r_o_outs   <= r_outs;
            r_o_steal  <= r_steal;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_o_status;
    assign o_job_out          = r_o_job;
    assign o_victim_index     = wsjs_pkg::WPORT_W'(r_o_victim);
    assign o_outstanding_jobs = r_o_outs;
    assign o_steal_total      = r_o_steal;

endmodule

`default_nettype wire

>>> hdl/wsjs_ctrl.sv
// ----------------------------------------------------------------------------
// wsjs_ctrl
// Request sequencer: decide, victim scan, memory read wait, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module wsjs_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire wsjs_pkg::t_dp_stat  i_stat,
    output wsjs_pkg::t_cmd           o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_SCAN = 5'b00100,
        S_RD   = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = wsjs_pkg::ST_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state          = S_FIN;
                o_cmd.set_status = 1'b1;
                unique case (i_stat.req)
                    wsjs_pkg::RQ_SUBMIT: begin
                        if (i_stat.has_own && !i_stat.own_full) begin
                            o_cmd.dq_push = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                            o_cmd.status  = wsjs_pkg::ST_PUSH_OWN;
                        end else if (!i_stat.ov_full) begin
                            o_cmd.ov_push = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                            o_cmd.status  = wsjs_pkg::ST_QUEUED_OV;
                        end else begin
                            o_cmd.status  = wsjs_pkg::ST_REJECTED;
                        end
                    end
                    wsjs_pkg::RQ_ACQUIRE: begin
                        if (i_stat.has_own && !i_stat.own_empty) begin
                            o_cmd.dq_pop = 1'b1;
                            o_cmd.status = wsjs_pkg::ST_GOT_OWN;
                            n_state      = S_RD;
                        end else if (!i_stat.ov_empty) begin
                            o_cmd.ov_pop = 1'b1;
                            o_cmd.status = wsjs_pkg::ST_GOT_OV;
                            n_state      = S_RD;
                        end else if (i_stat.multi) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    wsjs_pkg::RQ_COMPLETE: begin
                        o_cmd.cnt_dec = 1'b1;
                        o_cmd.status  = wsjs_pkg::ST_COMPLETED;
                    end
                    default: begin
                        o_cmd.status = wsjs_pkg::ST_NONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_FIN;
                end else if (i_stat.scan_skip) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    o_cmd.steal      = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = wsjs_pkg::ST_STOLEN;
                    n_state          = S_RD;
                end
            end
            S_RD: begin
                o_cmd.load_job = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> hdl/wsjs_checker.sv
// ----------------------------------------------------------------------------
// wsjs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wsjs_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [wsjs_pkg::STAT_W-1:0]   o_status,
    input wire logic [wsjs_pkg::JOB_W-1:0]    o_job_out,
    input wire logic [wsjs_pkg::WPORT_W-1:0]  o_victim_index
);

    // A waiting result word stays offered.
    `WSJS_ASSERT_IMP(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, ##1 o_out_valid, "result word dropped while stalled")

    // After a request is taken the block is busy with it.
    `WSJS_ASSERT_IMP(a_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, ##1 o_in_stall, "request side not stalled after accept")

    // Only a steal names a victim.
    `WSJS_ASSERT_IMP(a_victim, i_clk, i_rst_n, o_out_valid && (o_status != wsjs_pkg::ST_STOLEN), o_victim_index == '0, "victim set without a steal")

    // Only a successful acquire hands out a job.
    `WSJS_ASSERT_IMP(a_job, i_clk, i_rst_n, o_out_valid && ((o_status == wsjs_pkg::ST_NONE) || (o_status == wsjs_pkg::ST_COMPLETED) || (o_status == wsjs_pkg::ST_PUSH_OWN) || (o_status == wsjs_pkg::ST_QUEUED_OV) || (o_status == wsjs_pkg::ST_REJECTED)), o_job_out == '0, "job handed out without an acquire")

endmodule

bind work_stealing_job_scheduler wsjs_checker u_wsjs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_job_out      (o_job_out),
    .o_victim_index (o_victim_index)
);

`default_nettype wire
